>>> hdl/battery_level_gauge_defines.svh
// assertion helpers shared by the gauge rtl
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

// consequent checked in the same cycle
`define BLG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// consequent checked in the next cycle
`define BLG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

>>> hdl/blg_pkg.sv
`default_nettype none

package blg_pkg;

  localparam int MV_W     = 13;
  localparam int TIME_W   = 32;
  localparam int PCT_W    = 7;
  localparam int WEIGHT_W = 16;
  localparam int DEB_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int AVG_W    = MV_W + FRAC_W;
  localparam int PROD_W   = AVG_W + WEIGHT_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT           = 2'd2;

  localparam logic [MV_W-1:0]     RST_CHARGE_THRESHOLD = 13'd4320;
  localparam logic [DEB_W-1:0]    RST_DEBOUNCE         = 16'd2000;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT           = 16'd5243;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // voltage to percent steps, highest first
  localparam int LEVELS = 9;
  localparam logic [MV_W-1:0] LEVEL_MV [LEVELS] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
    13'd3700, 13'd3600, 13'd3500, 13'd3400
  };
  localparam logic [PCT_W-1:0] LEVEL_PCT [LEVELS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd30, 7'd20, 7'd10
  };
  localparam logic [PCT_W-1:0] PCT_FLOOR = 7'd5;

  typedef struct packed {
    logic [MV_W-1:0]   raw_mv;
    logic [TIME_W-1:0] now_ms;
    logic              busy_req;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             charging;
    logic [MV_W-1:0]  smoothed_mv;
  } out_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]  shown_percent;
    logic              shown_valid;
    logic              was_charging;
    logic [TIME_W-1:0] unplug_time;
  } disp_state_t;

  function automatic logic [PCT_W-1:0] table_percent(input logic [MV_W-1:0] mv);
    logic [PCT_W-1:0] pct;
    pct = PCT_FLOOR;
    // walk from the lowest step up so the highest match wins
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (mv >= LEVEL_MV[i]) begin
        pct = LEVEL_PCT[i];
      end
    end
    return pct;
  endfunction

endpackage

`default_nettype wire

>>> hdl/blg_if.sv
`default_nettype none

interface blg_in_if;
  logic               valid;
  logic               ready;
  blg_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface blg_out_if;
  logic               valid;
  logic               ready;
  blg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/blg_avg.sv
`default_nettype none

module blg_avg (
  input  wire logic [blg_pkg::AVG_W-1:0]    avg_i,
  input  wire logic [blg_pkg::MV_W-1:0]     raw_mv_i,
  input  wire logic [blg_pkg::WEIGHT_W-1:0] weight_i,
  output logic      [blg_pkg::AVG_W-1:0]    avg_o
);

  logic [blg_pkg::AVG_W-1:0]  target;
  logic [blg_pkg::AVG_W-1:0]  base;
  logic                       going_up;
  logic [blg_pkg::AVG_W-1:0]  diff;
  logic [blg_pkg::PROD_W-1:0] prod;
  logic [blg_pkg::PROD_W-1:0] prod_rnd;
  logic [blg_pkg::AVG_W-1:0]  step;

  always_comb begin
    target   = {raw_mv_i, {blg_pkg::FRAC_W{1'b0}}};
    // an empty average takes the sample as is
    base     = (avg_i == '0) ? target : avg_i;
    going_up = (target >= base);
    diff     = going_up ? (target - base) : (base - target);
    prod     = blg_pkg::PROD_W'(weight_i) * blg_pkg::PROD_W'(diff);
    // round half away from zero on the magnitude
    prod_rnd = prod + blg_pkg::PROD_W'(1 << (blg_pkg::FRAC_W - 1));
    step     = prod_rnd[blg_pkg::PROD_W-1:blg_pkg::FRAC_W];
    avg_o    = going_up ? (base + step) : (base - step);
  end

endmodule

`default_nettype wire

>>> hdl/blg_disp.sv
`default_nettype none

module blg_disp (
  input  wire logic [blg_pkg::MV_W-1:0]   avg_mv_i,
  input  wire logic [blg_pkg::MV_W-1:0]   raw_mv_i,
  input  wire logic [blg_pkg::TIME_W-1:0] now_ms_i,
  input  wire logic [blg_pkg::MV_W-1:0]   threshold_i,
  input  wire logic [blg_pkg::DEB_W-1:0]  debounce_i,
  input  wire blg_pkg::disp_state_t       state_i,
  output blg_pkg::disp_state_t            state_o
);

  logic [blg_pkg::PCT_W-1:0]  table_pct;
  logic [blg_pkg::PCT_W-1:0]  base_pct;
  logic                       charging;
  logic [blg_pkg::TIME_W-1:0] unplug;
  logic [blg_pkg::TIME_W-1:0] elapsed;
  logic                       slew_en;

  always_comb begin
    table_pct = blg_pkg::table_percent(avg_mv_i);
    base_pct  = state_i.shown_valid ? state_i.shown_percent : table_pct;
    charging  = (raw_mv_i > threshold_i);
    // falling edge of external power restarts the hold window
    unplug    = (state_i.was_charging && !charging) ? now_ms_i : state_i.unplug_time;
    elapsed   = now_ms_i - unplug;
    slew_en   = charging ||
                (elapsed >= {{(blg_pkg::TIME_W - blg_pkg::DEB_W){1'b0}}, debounce_i});

    state_o.shown_valid  = 1'b1;
    state_o.was_charging = charging;
    state_o.unplug_time  = unplug;
    state_o.shown_percent = base_pct;
    if (slew_en) begin
      if (table_pct > base_pct) begin
        state_o.shown_percent = base_pct + 7'd1;
      end else if (table_pct < base_pct) begin
        state_o.shown_percent = base_pct - 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/battery_level_gauge.sv
// channel  | dir | payload                                | handshake
// in_ch    | in  | raw_mv[13], now_ms[32], busy_req[1]    | valid/ready
// out_ch   | out | percent[7], charging[1], smoothed_mv[13] | valid/ready
// cfg      | in  | cfg_idx_i[2], cfg_wdata_i[16]          | cfg_we_i, no stall
//
// one tick per cycle sustained while results are taken; an accepted tick is held in the
// input stage, then loaded into the result register, which a held result can stall
// the update is combinational between the input stage and the result register
// reset clears the average, the shown percent and all valid flags
// a stalled result freezes both stages; input stays ready while the input stage
// is empty or the result register is empty or drains
`default_nettype none
`include "battery_level_gauge_defines.svh"

module battery_level_gauge (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [blg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [blg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  blg_in_if.sink                              in_ch,
  blg_out_if.source                           out_ch
);

  // configuration
  logic [blg_pkg::MV_W-1:0]     thresh_q;
  logic [blg_pkg::DEB_W-1:0]    debounce_q;
  logic [blg_pkg::WEIGHT_W-1:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= blg_pkg::RST_CHARGE_THRESHOLD;
      debounce_q <= blg_pkg::RST_DEBOUNCE;
      weight_q   <= blg_pkg::RST_WEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blg_pkg::CFG_CHARGE_THRESHOLD: thresh_q <= cfg_wdata_i[blg_pkg::MV_W-1:0];
        blg_pkg::CFG_DEBOUNCE:         debounce_q <= cfg_wdata_i[blg_pkg::DEB_W-1:0];
        blg_pkg::CFG_WEIGHT:           weight_q <= cfg_wdata_i[blg_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic               in_vld_q;
  blg_pkg::in_item_t  in_item_q;
  logic               out_vld_q;
  blg_pkg::out_item_t out_item_q;
  logic               adv;
  logic               in_ready;
  logic               upd;

  assign adv      = !out_vld_q || out_ch.ready;
  assign in_ready = !in_vld_q || adv;
  assign upd      = adv && in_vld_q && !in_item_q.busy_req;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch.valid) begin
      in_item_q <= in_ch.data;
    end
  end

  // gauge state
  logic [blg_pkg::AVG_W-1:0] avg_q;
  logic [blg_pkg::AVG_W-1:0] avg_d;
  logic [blg_pkg::AVG_W-1:0] avg_calc;
  blg_pkg::disp_state_t      disp_q;
  blg_pkg::disp_state_t      disp_d;
  blg_pkg::disp_state_t      disp_calc;

  blg_avg u_avg (
    .avg_i    (avg_q),
    .raw_mv_i (in_item_q.raw_mv),
    .weight_i (weight_q),
    .avg_o    (avg_calc)
  );

  blg_disp u_disp (
    .avg_mv_i    (avg_calc[blg_pkg::AVG_W-1:blg_pkg::FRAC_W]),
    .raw_mv_i    (in_item_q.raw_mv),
    .now_ms_i    (in_item_q.now_ms),
    .threshold_i (thresh_q),
    .debounce_i  (debounce_q),
    .state_i     (disp_q),
    .state_o     (disp_calc)
  );

  // busy ticks report the state unchanged
  assign avg_d  = in_item_q.busy_req ? avg_q : avg_calc;
  assign disp_d = in_item_q.busy_req ? disp_q : disp_calc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      disp_q <= '0;
    end else if (upd) begin
      avg_q  <= avg_d;
      disp_q <= disp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      out_item_q.percent     <= disp_d.shown_percent;
      out_item_q.charging    <= disp_d.was_charging;
      out_item_q.smoothed_mv <= avg_d[blg_pkg::AVG_W-1:blg_pkg::FRAC_W];
    end
  end

  `BLG_ASSERT_NOW(a_pct_range, clk_i, rst_ni, 1'b1, disp_q.shown_percent <= blg_pkg::PCT_MAX)
  `BLG_ASSERT_NEXT(a_init_after_update, clk_i, rst_ni, upd, disp_q.shown_valid)
  `BLG_ASSERT_NEXT(a_busy_holds, clk_i, rst_ni, adv && in_vld_q && in_item_q.busy_req, $stable(avg_q) && $stable(disp_q))
  `BLG_ASSERT_NEXT(a_slew_one, clk_i, rst_ni, disp_q.shown_valid, (disp_q.shown_percent == $past(disp_q.shown_percent)) || (disp_q.shown_percent == $past(disp_q.shown_percent) + 7'd1) || (disp_q.shown_percent == $past(disp_q.shown_percent) - 7'd1))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blg_pkg::*;

  localparam int LAT_CYCLES     = 2;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SHOW_ERRORS    = 10;
  localparam int STALL_CYCLES   = 160;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  blg_in_if  in_ch ();
  blg_out_if out_ch ();

  battery_level_gauge DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // register copies
  logic [MV_W-1:0]     thresh_mv;
  logic [DEB_W-1:0]    hold_ms;
  logic [WEIGHT_W-1:0] weight_q16;

  // gauge state copies
  logic [AVG_W-1:0]  avg_mv_q16;
  logic [PCT_W-1:0]  shown_pct;
  logic              shown_set;
  logic              on_charger;
  logic [TIME_W-1:0] unplug_ms;

  in_item_t  tick_q[$];
  out_item_t gauge_q[$];

  int  sent_cnt, busy_cnt, in_acc_cnt, out_cnt, err_cnt, cyc_cnt, cfg_cnt;
  int  stall_left, chg_seen;
  bit  in_taken, hold_done;
  int  batt_mv;
  logic [TIME_W-1:0] clock_ms;
  logic calm;

  // no idling on either side in this window
  assign calm = (in_acc_cnt >= 1000) && (in_acc_cnt < 1400);

  function automatic logic [PCT_W-1:0] level_pct_of(input logic [MV_W-1:0] mv);
    for (int i = 0; i < LEVELS; i++) begin
      if (mv >= LEVEL_MV[i]) begin
        return LEVEL_PCT[i];
      end
    end
    return PCT_FLOOR;
  endfunction

  function automatic out_item_t gauge_tick(input in_item_t t);
    out_item_t res;
    logic              chg;
    logic [31:0]       target, acc;
    logic [63:0]       diff, stp;
    logic [PCT_W-1:0]  lvl;
    logic [TIME_W-1:0] elapsed;
    if (!t.busy_req) begin
      chg = t.raw_mv > thresh_mv;
      target = {3'b000, t.raw_mv, 16'h0000};
      acc = {3'b000, avg_mv_q16};
      if (acc == 0) acc = target;
      // rounded step toward the sample, half away from zero
      if (target >= acc) begin
        diff = 64'(target - acc);
        stp = (weight_q16 * diff + 64'd32768) >> 16;
        acc = acc + stp[31:0];
      end else begin
        diff = 64'(acc - target);
        stp = (weight_q16 * diff + 64'd32768) >> 16;
        acc = acc - stp[31:0];
      end
      avg_mv_q16 = acc[AVG_W-1:0];
      lvl = level_pct_of(avg_mv_q16[AVG_W-1:FRAC_W]);
      if (!shown_set) begin
        shown_pct = lvl;
        shown_set = 1'b1;
      end
      if (on_charger && !chg) unplug_ms = t.now_ms;
      on_charger = chg;
      elapsed = t.now_ms - unplug_ms;
      if (chg || elapsed >= TIME_W'(hold_ms)) begin
        if (lvl > shown_pct) shown_pct++;
        else if (lvl < shown_pct) shown_pct--;
      end
    end
    res.percent     = shown_pct;
    res.charging    = on_charger;
    res.smoothed_mv = avg_mv_q16[AVG_W-1:FRAC_W];
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= SHOW_ERRORS) begin
        $display("ERROR result %0d: %s expected %0d, got %0d", out_cnt, name, want, got);
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CHARGE_THRESHOLD: thresh_mv = val[MV_W-1:0];
      CFG_DEBOUNCE:         hold_ms = val[DEB_W-1:0];
      CFG_WEIGHT:           weight_q16 = val[WEIGHT_W-1:0];
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_tick(input logic [MV_W-1:0] raw, input logic [TIME_W-1:0] now,
                          input logic busy);
    in_item_t t;
    t.raw_mv   = raw;
    t.now_ms   = now;
    t.busy_req = busy;
    tick_q.push_back(t);
    sent_cnt++;
    if (busy) busy_cnt++;
  endtask

  // mostly a wandering battery with a rising clock, some pure noise
  task automatic add_random_ticks(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        add_tick(MV_W'($urandom_range(8191)), $urandom(), $urandom_range(9) == 0);
      end else begin
        if (r < 18) batt_mv = $urandom_range(3300, 4500);
        else batt_mv = batt_mv + $urandom_range(80) - 40;
        if (batt_mv < 3200) batt_mv = 3200;
        if (batt_mv > 4500) batt_mv = 4500;
        clock_ms = clock_ms + $urandom_range(1500);
        add_tick(batt_mv[MV_W-1:0], clock_ms, $urandom_range(9) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (out_cnt != sent_cnt) @(negedge clk_i);
    repeat (LAT_CYCLES + 2) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cyc_cnt, out_cnt, sent_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        if (tick_q.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
          in_ch.data  <= tick_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off while the sender keeps offering
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && in_acc_cnt >= 600) begin
        hold_done  = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // transaction monitor and checker
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        gauge_q.push_back(gauge_tick(in_ch.data));
        in_acc_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_cnt++;
        if (out_ch.data.charging === 1'b1) chg_seen++;
        if (gauge_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_ERRORS) begin
            $display("ERROR result %0d arrived with nothing expected", out_cnt);
          end
        end else begin
          want = gauge_q.pop_front();
          check_field("percent", 32'(want.percent), 32'(out_ch.data.percent));
          check_field("charging", 32'(want.charging), 32'(out_ch.data.charging));
          check_field("smoothed_mv", 32'(want.smoothed_mv), 32'(out_ch.data.smoothed_mv));
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    thresh_mv    = RST_CHARGE_THRESHOLD;
    hold_ms      = RST_DEBOUNCE;
    weight_q16   = RST_WEIGHT;
    avg_mv_q16   = '0;
    shown_pct    = '0;
    shown_set    = 1'b0;
    on_charger   = 1'b0;
    unplug_ms    = '0;
    batt_mv      = 3800;
    clock_ms     = 32'd20000;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: busy before any update, zero sample, first load,
    // plug and unplug, threshold edge, debounce across timestamp wrap
    add_tick(13'd8191, 32'hFFFF_FFFF, 1'b1);
    add_tick(13'd0,    32'd0,         1'b0);
    add_tick(13'd3750, 32'd10,        1'b0);
    add_tick(13'd3750, 32'd5000,      1'b0);
    add_tick(13'd8191, 32'd6000,      1'b0);
    add_tick(13'd8191, 32'd6001,      1'b0);
    add_tick(13'd3000, 32'd7000,      1'b0);
    add_tick(13'd3000, 32'd7500,      1'b0);
    add_tick(13'd3000, 32'd9000,      1'b0);
    add_tick(13'd4321, 32'd9100,      1'b1);
    add_tick(13'd4320, 32'd9200,      1'b0);
    add_tick(13'd4321, 32'd9300,      1'b0);
    add_tick(13'd100,  32'hFFFF_FF00, 1'b0);
    add_tick(13'd100,  32'h0000_0100, 1'b0);
    add_tick(13'd100,  32'h0000_1000, 1'b0);
    wait_drained();

    // near-full weight, no debounce, never charging: walk down the table steps
    write_reg(CFG_CHARGE_THRESHOLD, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_WEIGHT, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h1234);
    add_tick(13'd4250, 32'd100, 1'b0);
    for (int i = 0; i < LEVELS; i++) begin
      add_tick(LEVEL_MV[i], 32'd200 + i, 1'b0);
    end
    add_tick(13'd3399, 32'd300, 1'b0);
    add_random_ticks(150);
    wait_drained();

    write_reg(CFG_CHARGE_THRESHOLD, 16'd0);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_WEIGHT, 16'd1);
    add_random_ticks(200);
    wait_drained();

    // zero weight holds the average
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_CHARGE_THRESHOLD, 16'd4100);
    write_reg(CFG_DEBOUNCE, 16'd300);
    add_random_ticks(100);
    wait_drained();

    write_reg(CFG_CHARGE_THRESHOLD, 16'($urandom()));
    write_reg(CFG_DEBOUNCE, 16'($urandom()));
    write_reg(CFG_WEIGHT, 16'($urandom_range(1, 65535)));
    clock_ms = 32'hFFFF_0000;
    add_random_ticks(300);
    wait_drained();

    write_reg(CFG_CHARGE_THRESHOLD, CFG_DATA_W'(RST_CHARGE_THRESHOLD));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(RST_DEBOUNCE));
    write_reg(CFG_WEIGHT, CFG_DATA_W'(RST_WEIGHT));
    add_random_ticks(1200);
    wait_drained();

    if (gauge_q.size() != 0) begin
      err_cnt += gauge_q.size();
      $display("ERROR %0d expected results never arrived", gauge_q.size());
    end
    $display("ran %0d ticks (%0d busy) under %0d register writes; %0d results checked",
             sent_cnt, busy_cnt, cfg_cnt, out_cnt);
    $display("%0d results reported charging, %0d mismatches", chg_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
